// ===== design/bmpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpl_pkg
// shared types and constants of the binomial residue block
// ----------------------------------------------------------------------------
`default_nettype none
package bmpl_pkg;
  localparam int RES_W = 14;
  localparam int LEN_W = 7; // counts digit and exponent steps

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,  // latch n, k, p; acc <= 1 mod p
    OP_FILL0    = 4'd2,  // table[0] <= 1 mod p, idx <= 1
    OP_FILL     = 4'd3,  // start mult fact*idx
    OP_FILL_WR  = 4'd4,  // write product, idx++
    OP_DIG      = 4'd5,  // start n / p and k / p
    OP_RD_B     = 4'd6,  // read fact(b)
    OP_RD_AB    = 4'd7,  // read fact(a-b)
    OP_RD_A     = 4'd8,  // read fact(a)
    OP_POW_INIT = 4'd9,  // latch fact(a) into fa
    OP_POW_MUL  = 4'd10, // start acc*sq or sq*sq
    OP_POW_WR   = 4'd11, // write product back
    OP_ACC_MUL  = 4'd12, // start acc*fa, or fb*rd for den
    OP_ACC_WR   = 4'd13,
    OP_ZERO     = 4'd14
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel; // operand and write-back choice for the multi-step ops
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic fill_end;  // idx reached p or depth
    logic nk_zero;   // n or k zero
    logic a_lt_b;
    logic exp_zero;
    logic exp_bit;
    logic bad;       // k > n or p out of range
    logic table_ok;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/bmpl_mulmod.sv =====
// ----------------------------------------------------------------------------
// bmpl_mulmod
// x*y mod m: one registered multiply, then a bit-serial reduction
// ----------------------------------------------------------------------------
`default_nettype none
module bmpl_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bmpl_pkg::RES_W-1:0] x,
  input  logic [bmpl_pkg::RES_W-1:0] y,
  input  logic [bmpl_pkg::RES_W-1:0] m,
  output logic                      done,
  output logic [bmpl_pkg::RES_W-1:0] r
);
  import bmpl_pkg::*;
  localparam int PW = 2*RES_W;

  logic [PW-1:0]    prod;
  logic [RES_W:0]   rem;
  logic [RES_W:0]   shifted;
  logic [5:0]       cnt;
  logic             busy;
  logic             mul_st;

  assign shifted = {rem[RES_W-1:0], prod[PW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mul_st <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= PW'(x) * PW'(y);
        rem <= '0;
        cnt <= 6'(PW);
        busy <= 1'b1;
      end else if (busy) begin
        // restoring remainder, one product bit a cycle
        if (shifted >= {1'b0, m}) rem <= shifted - {1'b0, m};
        else rem <= shifted;
        prod <= {prod[PW-2:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      mul_st <= start;
    end
  end
  assign r = rem[RES_W-1:0];

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_done: assert property (p_done_after_busy) else $error("done while busy");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("restart while busy");
  a_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double done");
  // keep mul_st used
  a_st: assert property (@(posedge clk) disable iff (rst)
    mul_st |-> busy) else $error("start without busy");
endmodule
`default_nettype wire

// ===== design/bmpl_divp.sv =====
// ----------------------------------------------------------------------------
// bmpl_divp
// value / m and value % m, restoring division one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module bmpl_divp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [VALUE_BITS-1:0]     value,
  input  logic [bmpl_pkg::RES_W-1:0] m,
  output logic                      done,
  output logic [VALUE_BITS-1:0]     quot,
  output logic [bmpl_pkg::RES_W-1:0] rem
);
  import bmpl_pkg::*;
  localparam int CW = $clog2(VALUE_BITS+1);

  logic [RES_W:0]  r;
  logic [RES_W:0]  sh;
  logic [CW-1:0]   cnt;
  logic            busy;

  assign sh = {r[RES_W-1:0], quot[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= value;
        r <= '0;
        cnt <= CW'(VALUE_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        if (sh >= {1'b0, m}) begin
          r <= sh - {1'b0, m};
          quot <= {quot[VALUE_BITS-2:0], 1'b1};
        end else begin
          r <= sh;
          quot <= {quot[VALUE_BITS-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = r[RES_W-1:0];
endmodule
`default_nettype wire

// ===== design/bmpl_datapath.sv =====
// ----------------------------------------------------------------------------
// bmpl_datapath
// operand registers, factorial memory, shared mulmod and digit dividers
// ----------------------------------------------------------------------------
`default_nettype none
module bmpl_datapath #(
  parameter int TABLE_DEPTH = 16384,
  parameter int VALUE_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bmpl_pkg::cmd_t            cmd,
  input  logic [VALUE_BITS-1:0]     n_in,
  input  logic [VALUE_BITS-1:0]     k_in,
  input  logic [bmpl_pkg::RES_W-1:0] p_in,
  output bmpl_pkg::stat_t           stat,
  output logic [bmpl_pkg::RES_W-1:0] result
);
  import bmpl_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 1;

  logic [RES_W-1:0]      mem [TABLE_DEPTH];
  logic [RES_W-1:0]      rd;
  logic [AW-1:0]         raddr;
  logic                  wen;
  logic [AW-1:0]         waddr;
  logic [RES_W-1:0]      wdata;

  logic [VALUE_BITS-1:0] n, k;
  logic [RES_W-1:0]      p, table_prime, acc, sq, fb, fa, fact, expo;
  logic [RES_W-1:0]      a, b;
  logic [IW-1:0]         idx;
  logic                  start_m, start_d, done_n, done_k, got_n, got_k;
  logic                  mul_done, bad;
  logic [RES_W-1:0]      mx, my, mr;
  logic [VALUE_BITS-1:0] qn, qk;
  logic [RES_W-1:0]      rn, rk;
  logic [RES_W:0]        diff;

  bmpl_mulmod u_mul (.clk, .rst, .start(start_m), .x(mx), .y(my), .m(p),
                     .done(mul_done), .r(mr));
  bmpl_divp #(.VALUE_BITS(VALUE_BITS)) u_divn (.clk, .rst, .start(start_d),
    .value(n), .m(p), .done(done_n), .quot(qn), .rem(rn));
  bmpl_divp #(.VALUE_BITS(VALUE_BITS)) u_divk (.clk, .rst, .start(start_d),
    .value(k), .m(p), .done(done_k), .quot(qk), .rem(rk));

  // digit a < p <= depth, so it always indexes the table
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_comb begin
    raddr = '0;
    case (cmd.op)
      OP_RD_B:  raddr = AW'(b);
      OP_RD_AB: raddr = AW'(a - b);
      OP_RD_A:  raddr = AW'(a);
      default:  raddr = '0;
    endcase
  end

  assign wen   = (cmd.op == OP_FILL0) || (cmd.op == OP_FILL_WR);
  assign waddr = (cmd.op == OP_FILL0) ? '0 : idx[AW-1:0];
  assign wdata = (cmd.op == OP_FILL0) ? ((p == RES_W'(1)) ? '0 : RES_W'(1)) : mr;
  assign start_m = (cmd.op == OP_FILL) || (cmd.op == OP_POW_MUL) ||
                   (cmd.op == OP_ACC_MUL) || (cmd.op == OP_POW_INIT && 1'b0);
  assign start_d = (cmd.op == OP_DIG);

  always_comb begin
    mx = acc;
    my = sq;
    case (cmd.op)
      OP_FILL:    begin mx = fact; my = RES_W'(idx); end
      OP_POW_MUL: begin mx = cmd.sel ? sq : acc; my = sq; end
      OP_ACC_MUL: begin mx = cmd.sel ? fb : acc; my = cmd.sel ? rd : fa; end
      default:    begin mx = acc; my = sq; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_prime <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          n <= n_in; k <= k_in; p <= p_in;
          acc <= bad ? '0 : RES_W'(1);
          got_n <= 1'b0; got_k <= 1'b0;
        end
        OP_FILL0: begin
          fact <= wdata;
          idx <= IW'(1);
        end
        OP_FILL_WR: begin
          fact <= mr;
          idx <= idx + IW'(1);
          table_prime <= p;
        end
        OP_DIG: begin
          got_n <= 1'b0; got_k <= 1'b0;
        end
        OP_RD_AB: fb <= rd;
        OP_RD_A: ;
        OP_POW_INIT: begin
          // den = fact(b)*fact(a-b) is still in the mulmod; fa read last cycle
          fa <= rd;
        end
        OP_POW_WR: begin
          if (cmd.sel) begin
            sq <= mr;
            expo <= expo >> 1;
          end else acc <= mr;
        end
        OP_ACC_WR: begin
          if (cmd.sel) begin
            // den ready: start power setup
            sq <= mr;
            expo <= p - RES_W'(2);
            fb <= acc;       // save running product
            acc <= (p == RES_W'(1)) ? '0 : RES_W'(1);
          end else begin
            // inv*fact(a) first, then times the running product
            acc <= mr;
            fa <= fb;
          end
        end
        OP_ZERO: acc <= '0;
        default: ;
      endcase
      if (done_n) begin n <= qn; a <= rn; got_n <= 1'b1; end
      if (done_k) begin k <= qk; b <= rk; got_k <= 1'b1; end
      if (cmd.op == OP_FILL && idx == IW'(1)) table_prime <= '0;
    end
  end

  assign diff = {1'b0, a} - {1'b0, b};
  assign bad  = (p_in < RES_W'(2)) || (32'(p_in) > 32'(TABLE_DEPTH)) ||
                (k_in > n_in);
  assign stat = '{mul_done: mul_done,
                  div_done: got_n && got_k,
                  fill_end: (IW'(p) == idx) || (idx == IW'(TABLE_DEPTH)),
                  nk_zero:  (n == '0) || (k == '0),
                  a_lt_b:   diff[RES_W],
                  exp_zero: (expo == '0),
                  exp_bit:  expo[0],
                  bad:      bad,
                  table_ok: (table_prime == p_in)};
  assign result = acc;
endmodule
`default_nettype wire

// ===== design/bmpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmpl_ctrl
// sequencer: table build, digit loop, fermat power, output register
// ----------------------------------------------------------------------------
`default_nettype none
module bmpl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic [bmpl_pkg::RES_W-1:0] result,
  output logic [bmpl_pkg::RES_W-1:0] out_data,
  input  bmpl_pkg::stat_t           stat,
  output bmpl_pkg::cmd_t            cmd
);
  import bmpl_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001, S_FILL0 = 16'h0002, S_FILL = 16'h0004,
    S_FWAIT  = 16'h0008, S_DIG   = 16'h0010, S_DWAIT = 16'h0020,
    S_RDB    = 16'h0040, S_RDAB  = 16'h0080, S_RDA   = 16'h0100,
    S_DEN    = 16'h0200, S_DWR   = 16'h0400, S_POW   = 16'h0800,
    S_PWAIT  = 16'h1000, S_FIN   = 16'h2000, S_FWR   = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   phase, phase_next;      // pow: 0 multiply acc, 1 square
  logic [1:0] fin, fin_next;      // final: inv*fact(a), then times the running product
  logic   load_out;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    phase_next = phase;
    fin_next = fin;
    cmd = '{op: OP_NONE, sel: 1'b0};
    load_out = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (stat.bad) begin
          cmd.op = OP_LOAD; state_next = S_DONE;
          // zero result on bad query
        end else begin
          cmd.op = OP_LOAD;
          state_next = stat.table_ok ? S_DIG : S_FILL0;
        end
      end
      S_FILL0: begin cmd.op = OP_FILL0; state_next = S_FILL; end
      S_FILL: begin
        if (stat.fill_end) state_next = S_DIG;
        else begin cmd.op = OP_FILL; state_next = S_FWAIT; end
      end
      S_FWAIT: if (stat.mul_done) begin cmd.op = OP_FILL_WR; state_next = S_FILL; end
      S_DIG: begin
        if (stat.nk_zero) state_next = S_DONE;
        else begin cmd.op = OP_DIG; state_next = S_DWAIT; end
      end
      S_DWAIT: if (stat.div_done) begin
        if (stat.a_lt_b) begin cmd.op = OP_ZERO; state_next = S_DONE; end
        else begin cmd.op = OP_RD_B; state_next = S_RDB; end
      end
      S_RDB: begin cmd.op = OP_RD_AB; state_next = S_RDAB; end
      // fb holds fact(b); rd now fact(a-b)
      S_RDAB: begin cmd.op = OP_ACC_MUL; cmd.sel = 1'b1; state_next = S_DEN; end
      S_DEN: begin cmd.op = OP_RD_A; state_next = S_RDA; end
      S_RDA: begin cmd.op = OP_POW_INIT; state_next = S_DWR; end
      S_DWR: if (stat.mul_done) begin
        cmd.op = OP_ACC_WR; cmd.sel = 1'b1; phase_next = 1'b0; state_next = S_POW;
      end
      S_POW: begin
        if (stat.exp_zero) begin
          fin_next = 2'd0; state_next = S_FIN;
        end else if (!phase && !stat.exp_bit) begin
          phase_next = 1'b1;
        end else begin
          cmd.op = OP_POW_MUL; cmd.sel = phase; state_next = S_PWAIT;
        end
      end
      S_PWAIT: if (stat.mul_done) begin
        cmd.op = OP_POW_WR; cmd.sel = phase; phase_next = !phase; state_next = S_POW;
      end
      // first pass: acc = inv, fb = running product, fa = fact(a)
      S_FIN: begin cmd.op = OP_ACC_MUL; cmd.sel = 1'b0; state_next = S_FWR; end
      S_FWR: if (stat.mul_done) begin
        cmd.op = OP_ACC_WR; cmd.sel = 1'b0;
        fin_next = fin + 2'd1;
        state_next = (fin == 2'd1) ? S_DIG : S_FIN;
      end
      S_DONE: begin load_out = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      phase <= 1'b0;
      fin <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      fin <= fin_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) if (load_out) out_data <= result;

  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_load: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready)) else $error("output overrun");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== design/binomial_mod_prime_lucas_top.sv =====
// ----------------------------------------------------------------------------
// binomial_mod_prime_lucas_top
// C(n,k) mod p by lucas digits, factorial table and fermat inverse
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)            handshake
// s_axis    in   top_value[31:0], choose_value[63:32]   tvalid/tready
// m_axis    out  binomial_residue[13:0]                 tvalid/tready
// cfg       in   prime_modulus[13:0]                    cfg_valid/cfg_ready
// one query at a time; each digit costs a division of n and k by p plus up to
// 31 serial mulmods (den, up to 28 for the power, two final) on the
// shared mulmod unit; k > n or a bad p goes straight to a zero result.
// the factorial table is built once after a new p.
// rst synchronous; output register holds while m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module binomial_mod_prime_lucas_top #(
  parameter int TABLE_DEPTH = 16384,
  parameter int VALUE_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [2*VALUE_BITS-1:0]   s_axis_tdata,  // top_value, choose_value
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // binomial_residue
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data       // prime_modulus
);
  import bmpl_pkg::*;

  logic [RES_W-1:0] prime, res, od;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) prime <= RES_W'(2);
    else if (cfg_valid && cfg_ready) prime <= cfg_data[RES_W-1:0];
  end

  bmpl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd,
    .n_in(s_axis_tdata[VALUE_BITS-1:0]),
    .k_in(s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .p_in(prime), .stat, .result(res));

  bmpl_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .result(res), .out_data(od), .stat, .cmd);

  assign m_axis_tdata = {2'b00, od};
endmodule
`default_nettype wire

// ===== tb/tb_binomial_mod_prime_lucas_top.sv =====
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_lucas_top
// checks C(n,k) mod p over a range of moduli, including degenerate and
// non-prime ones, against a behavioral predictor. Queries are driven on the
// input stream with random gaps, results are read with random backpressure
// and compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

class residue_board;
  bit [13:0] prime;
  bit [13:0] fact_mod[16384];
  bit [15:0] want_q[$];
  int        errors;

  // factorial table for the current modulus, built whenever it changes
  function void set_prime(bit [13:0] p);
    longint unsigned f;
    prime = p;
    if (p >= 2) begin
      fact_mod[0] = 1 % p;
      for (int i = 1; i < p; i++) begin
        f = (longint'(fact_mod[i-1]) * i) % p;
        fact_mod[i] = f[13:0];
      end
    end
  endfunction

  function void note_query(bit [31:0] n, bit [31:0] k);
    longint unsigned p, nn, kk, a, b, acc, den, inv, sq, e;
    p = prime;
    acc = 0;
    if (p >= 2 && k <= n) begin
      acc = 1 % p;
      nn = n;
      kk = k;
      while (nn != 0 && kk != 0) begin
        a = nn % p;
        b = kk % p;
        if (a < b) begin
          acc = 0;
          break;
        end
        den = (longint'(fact_mod[b]) * fact_mod[a-b]) % p;
        // fermat inverse, power p-2
        e = p - 2;
        inv = 1 % p;
        sq = den % p;
        while (e != 0) begin
          if (e[0]) inv = (inv * sq) % p;
          sq = (sq * sq) % p;
          e = e >> 1;
        end
        acc = (((acc * fact_mod[a]) % p) * inv) % p;
        nn = nn / p;
        kk = kk / p;
      end
    end
    want_q.push_back({2'b00, acc[13:0]});
  endfunction

  function void check_residue(bit [15:0] got);
    bit [15:0] want;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, got);
      errors++;
    end else begin
      want = want_q.pop_front();
      if (got !== want) begin
        $display("%0t: residue expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_binomial_mod_prime_lucas_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // top_value, choose_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // binomial_residue
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;      // prime_modulus

  residue_board board = new();
  bit  sender_calm;
  int  results_seen;

  binomial_mod_prime_lucas_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic push_query(bit [31:0] n, bit [31:0] k);
    while (!sender_calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {k, n};
    do @(posedge clk); while (!s_axis_tready);
    board.note_query(n, k);
  endtask

  task automatic stop_queries();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // only written with the block drained
  task automatic write_prime(bit [13:0] p);
    wait (board.want_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= {2'b00, p};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_prime(p);
  endtask

  task automatic random_queries(int count);
    bit [31:0] n, k, t;
    int w;
    for (int i = 0; i < count; i++) begin
      n = $urandom();
      w = $urandom_range(32);
      k = 32'($urandom() & ((64'd1 << w) - 1));
      case ($urandom_range(9))
        0: k = 32'(n + 1 + ($urandom() & ((64'd1 << $urandom_range(32)) - 1) & ~n));
        1: k = n;
        2: k = 0;
        3: k = $urandom();
        default: if (k > n) begin t = n; n = k; k = t; end
      endcase
      push_query(n, k);
    end
    stop_queries();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    board.set_prime(14'd2);
    // reset modulus, field extremes and the k > n case
    push_query(32'd0, 32'd0);
    push_query('1, '1);
    push_query('1, 32'd0);
    push_query(32'd0, '1);
    push_query(32'd5, 32'd6);
    push_query(32'hFFFF_FFFE, '1);
    push_query('1, 32'd1);
    push_query(32'hAAAA_AAAA, 32'h5555_5555);
    push_query(32'h5555_5555, 32'h1555_5555);
    push_query(32'd4, 32'd1);
    stop_queries();
    random_queries(140);
    write_prime(14'd3);
    push_query(32'd7, 32'd5);   // lower digit of k above that of n
    push_query(32'd8, 32'd4);
    random_queries(140);
    write_prime(14'd0);
    random_queries(15);
    write_prime(14'd1);
    random_queries(15);
    write_prime(14'd13);
    sender_calm = 1'b1;
    random_queries(200);
    sender_calm = 1'b0;
    write_prime(14'd101);
    random_queries(250);
    write_prime(14'd4);         // not prime
    random_queries(60);
    write_prime(14'd10007);
    push_query(32'd10006, 32'd5000);
    push_query('1, 32'h0001_0000);
    random_queries(140);
    write_prime(14'd16381);
    push_query(32'd16380, 32'd8190);
    push_query('1, '1);
    random_queries(70);
    write_prime(14'd16383);     // largest field value, not prime
    random_queries(30);
    wait (board.want_q.size() == 0);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.want_q.size() == 0) begin
      $display("binomial_mod_prime_lucas_top: match");
    end else begin
      $display("binomial_mod_prime_lucas_top: mismatch");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, a calm stretch
  initial begin
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_residue(m_axis_tdata);
        results_seen++;
      end
      if (results_seen == 300 && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (results_seen >= 400 && results_seen < 600) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // ends the run if no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) || rst)
        quiet = 0;
      else
        quiet++;
      if (quiet >= 3000000) begin
        $display("binomial_mod_prime_lucas_top: mismatch");
        $finish;
      end
    end
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
design/bmpl_pkg.sv
design/bmpl_mulmod.sv
design/bmpl_divp.sv
design/bmpl_datapath.sv
design/bmpl_ctrl.sv
design/binomial_mod_prime_lucas_top.sv
tb/tb_binomial_mod_prime_lucas_top.sv
